// File: hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master status sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   localparam int TX_DEPTH = 4;
   localparam int RX_DEPTH = 16;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TX_LENGTH      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RX_LENGTH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TX_BYTES       = 3'd4;

   // controller status codes
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RSTART      = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
   localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
   localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
   localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

   typedef struct packed {
      logic        read_mode;
      logic [6:0]  device_address;
      logic [2:0]  tx_length;
      logic [4:0]  rx_length;
      logic [31:0] tx_bytes;
   } cfg_type;

   typedef struct packed {
      logic       load_valid;
      logic [7:0] load_byte;
      logic       ctl_start;
      logic       ctl_stop;
      logic       ctl_ack;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [3:0] rx_index;
      logic       done_res;
      logic       unexpected;
   } result_type;

endpackage

// File: hdl/i2c_master_status_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer
// Turns I2C controller status events into the next bus action.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | status code, data byte
//   rsp     | out       | rsp_valid/rsp_stall  | bus action and rx report
//   csr     | in        | csr_write_en         | register index, data
//
// One beat per cycle sustained while rsp_stall is low; path: input register,
// then result register. The transfer counters advance as a beat moves from the
// input register into the result register. Reset clears both valids, the
// counters and loads the register defaults. A stalled result holds the
// result register; the input register keeps accepting until it is full.
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [i2cms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_bus_status,
   input  logic [7:0]                         req_bus_data_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_load_valid,
   output logic [7:0]                         rsp_load_byte,
   output logic                               rsp_ctl_start,
   output logic                               rsp_ctl_stop,
   output logic                               rsp_ctl_ack,
   output logic                               rsp_rx_valid,
   output logic [7:0]                         rsp_rx_byte,
   output logic [3:0]                         rsp_rx_index,
   output logic                               rsp_done_res,
   output logic                               rsp_unexpected
);
   import i2cms_pkg::*;

   cfg_type    cfg;
   result_type step_result;
   result_type res_ff;
   logic       res_valid_ff;
   logic       in_valid_ff;
   logic [7:0] status_ff;
   logic [7:0] data_ff;
   logic [2:0] sent_ff;
   logic [2:0] sent_in;
   logic [4:0] recv_ff;
   logic [4:0] recv_in;
   logic       res_open;
   logic       move;
   logic       take;

   i2cms_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   i2cms_step u_step (
      .bus_status          (status_ff),
      .bus_data_in         (data_ff),
      .cfg                 (cfg),
      .sent_count          (sent_ff),
      .received_count      (recv_ff),
      .result              (step_result),
      .sent_count_next     (sent_in),
      .received_count_next (recv_in)
   );

   assign res_open  = !res_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && res_open;
   assign req_stall = in_valid_ff && !res_open;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         sent_ff      <= 3'd0;
         recv_ff      <= 5'd0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (res_open) begin
            res_valid_ff <= in_valid_ff;
         end
         if (move) begin
            sent_ff <= sent_in;
            recv_ff <= recv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= req_bus_status;
         data_ff   <= req_bus_data_in;
      end
      if (move) begin
         res_ff <= step_result;
      end
   end

   assign rsp_valid      = res_valid_ff;
   assign rsp_load_valid = res_ff.load_valid;
   assign rsp_load_byte  = res_ff.load_byte;
   assign rsp_ctl_start  = res_ff.ctl_start;
   assign rsp_ctl_stop   = res_ff.ctl_stop;
   assign rsp_ctl_ack    = res_ff.ctl_ack;
   assign rsp_rx_valid   = res_ff.rx_valid;
   assign rsp_rx_byte    = res_ff.rx_byte;
   assign rsp_rx_index   = res_ff.rx_index;
   assign rsp_done_res   = res_ff.done_res;
   assign rsp_unexpected = res_ff.unexpected;

endmodule

// File: hdl/i2cms_csr.sv
// ----------------------------------------------------------------------------
// i2cms_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module i2cms_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [i2cms_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0]   csr_data,
   output i2cms_pkg::cfg_type                 cfg
);
   import i2cms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_READ_MODE:      cfg_in.read_mode      = csr_data[0];
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_data[6:0];
            CSR_TX_LENGTH:      cfg_in.tx_length      = csr_data[2:0];
            CSR_RX_LENGTH:      cfg_in.rx_length      = csr_data[4:0];
            CSR_TX_BYTES:       cfg_in.tx_bytes       = csr_data[31:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_mode      <= 1'b0;
         cfg_ff.device_address <= 7'd64;
         cfg_ff.tx_length      <= 3'd1;
         cfg_ff.rx_length      <= 5'd3;
         cfg_ff.tx_bytes       <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/i2cms_step.sv
// ----------------------------------------------------------------------------
// i2cms_step
// Decision logic for one status event: next bus action and counter update.
// ----------------------------------------------------------------------------
module i2cms_step (
   input  logic [7:0]            bus_status,
   input  logic [7:0]            bus_data_in,
   input  i2cms_pkg::cfg_type    cfg,
   input  logic [2:0]            sent_count,
   input  logic [4:0]            received_count,
   output i2cms_pkg::result_type result,
   output logic [2:0]            sent_count_next,
   output logic [4:0]            received_count_next
);
   import i2cms_pkg::*;

   logic [2:0] txl;
   logic [4:0] rxl;
   logic [7:0] addr_w;
   logic [7:0] tx_cur;
   logic [7:0] tx_first;
   logic [4:0] recv_inc;
   logic [5:0] recv_inc_p1;
   logic       stop;

   always_comb begin
      if (cfg.tx_length == 3'd0) begin
         txl = 3'd1;
      end else if (int'(cfg.tx_length) > TX_DEPTH) begin
         txl = 3'(TX_DEPTH);
      end else begin
         txl = cfg.tx_length;
      end

      if (cfg.rx_length == 5'd0) begin
         rxl = 5'd1;
      end else if (int'(cfg.rx_length) > RX_DEPTH) begin
         rxl = 5'(RX_DEPTH);
      end else begin
         rxl = cfg.rx_length;
      end
   end

   assign addr_w = {cfg.device_address, 1'b0};

   // bytes past the stored word, or past the depth, send as zero
   assign tx_cur = (sent_count < 3'd4 && int'(sent_count) < TX_DEPTH)
                   ? 8'(cfg.tx_bytes >> {sent_count[1:0], 3'b000}) : 8'd0;
   assign tx_first = cfg.tx_bytes[7:0];

   assign recv_inc    = (received_count != 5'd31) ? received_count + 5'd1 : 5'd31;
   assign recv_inc_p1 = {1'b0, recv_inc} + 6'd1;

   always_comb begin
      result              = '0;
      stop                = 1'b0;
      sent_count_next     = sent_count;
      received_count_next = received_count;

      if (!cfg.read_mode) begin
         if (bus_status == ST_START) begin
            result.load_valid = 1'b1;
            result.load_byte  = addr_w;
         end else if (bus_status == ST_ADDR_W_ACK ||
                      (bus_status == ST_DATA_W_ACK && sent_count < txl)) begin
            result.load_valid = 1'b1;
            result.load_byte  = tx_cur;
            if (sent_count != 3'd7) begin
               sent_count_next = sent_count + 3'd1;
            end
         end else if (bus_status == ST_DATA_W_ACK) begin
            stop            = 1'b1;
            result.done_res = 1'b1;
         end else if (bus_status == ST_ADDR_W_NACK) begin
            stop = 1'b1;
         end else begin
            stop              = 1'b1;
            result.unexpected = 1'b1;
         end
      end else begin
         case (bus_status)
            ST_START: begin
               result.load_valid = 1'b1;
               result.load_byte  = addr_w;
            end
            ST_ADDR_W_ACK: begin
               result.load_valid = 1'b1;
               result.load_byte  = tx_first;
            end
            ST_ADDR_W_NACK: stop = 1'b1;
            ST_DATA_W_ACK:  result.ctl_start = 1'b1;
            ST_RSTART: begin
               result.load_valid = 1'b1;
               result.load_byte  = addr_w | 8'd1;
            end
            ST_ADDR_R_ACK: result.ctl_ack = (rxl > 5'd1);
            ST_DATA_R_ACK: begin
               result.rx_valid     = 1'b1;
               result.rx_byte      = bus_data_in;
               result.rx_index     = received_count[3:0];
               received_count_next = recv_inc;
               result.ctl_ack      = (recv_inc_p1 < {1'b0, rxl});
            end
            ST_DATA_R_NACK: begin
               result.rx_valid = 1'b1;
               result.rx_byte  = bus_data_in;
               result.rx_index = received_count[3:0];
               stop            = 1'b1;
               result.done_res = 1'b1;
            end
            default: begin
               stop              = 1'b1;
               result.unexpected = 1'b1;
            end
         endcase
      end

      if (stop) begin
         result.ctl_stop     = 1'b1;
         sent_count_next     = 3'd0;
         received_count_next = 5'd0;
      end
   end

endmodule

// File: dv/i2c_master_status_sequencer_test.sv
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer_test
// Self-checking bench for the I2C master status sequencer. Status events
// (directed ones first, then random write and read transfers, broken
// transfers, long runs and noise) go in under several register settings.
// Each accepted event is predicted against a shadow of the registers and of
// the transfer counters. Results are compared field by field in order, with
// random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module i2c_master_status_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cms_pkg::*;

   localparam int RANDOM_ITEMS   = 400;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] status;
      logic [7:0] data;
   } status_event_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_bus_status = '0;
   logic [7:0]             req_bus_data_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_load_valid;
   logic [7:0]             rsp_load_byte;
   logic                   rsp_ctl_start;
   logic                   rsp_ctl_stop;
   logic                   rsp_ctl_ack;
   logic                   rsp_rx_valid;
   logic [7:0]             rsp_rx_byte;
   logic [3:0]             rsp_rx_index;
   logic                   rsp_done_res;
   logic                   rsp_unexpected;

   i2c_master_status_sequencer dut (.*);

   // status events waiting for the driver, scratch for building transfers
   status_event_type queued_events[$];
   status_event_type seq[$];
   // bus actions predicted but not yet seen on the result channel
   result_type    pending_actions[$];

   // shadow of the registers and transfer counters
   cfg_type    reg_shadow;
   logic [2:0] sent_cnt;
   logic [4:0] recv_cnt;

   logic [7:0] known_codes[8] = '{ST_START, ST_RSTART, ST_ADDR_W_ACK, ST_ADDR_W_NACK,
                                  ST_DATA_W_ACK, ST_ADDR_R_ACK, ST_DATA_R_ACK,
                                  ST_DATA_R_NACK};

   int gap_odds = 0;    // 1-in-N chance of an idle burst after a beat, 0 = none
   int stall_odds = 0;
   int gap_left;
   int stall_left;
   int stuck_cycles;
   int mismatches = 0;
   int beats_in = 0;
   int beats_out = 0;
   int transfers_done = 0;
   int unexpected_seen = 0;
   int settings_used = 0;
   int events_staged = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int clamp_len(int value, int depth);
      if (value < 1) return 1;
      if (value > depth) return depth;
      return value;
   endfunction

   function automatic logic [7:0] tx_byte(int idx);
      if (idx >= 4 || idx >= TX_DEPTH) return 8'h00;
      return reg_shadow.tx_bytes[8*idx +: 8];
   endfunction

   // next bus action for one status event; advances the shadow counters
   function automatic result_type next_bus_action(logic [7:0] status, logic [7:0] data);
      result_type r;
      logic [7:0] addr_w;
      int         txl;
      int         rxl;
      int         nxt;
      logic       stop;
      r      = '0;
      stop   = 1'b0;
      addr_w = {reg_shadow.device_address, 1'b0};
      txl    = clamp_len(int'(reg_shadow.tx_length), TX_DEPTH);
      rxl    = clamp_len(int'(reg_shadow.rx_length), RX_DEPTH);
      if (!reg_shadow.read_mode) begin
         if (status == ST_START) begin
            r.load_valid = 1'b1;
            r.load_byte  = addr_w;
         end else if (status == ST_ADDR_W_ACK || (status == ST_DATA_W_ACK && sent_cnt < txl)) begin
            r.load_valid = 1'b1;
            r.load_byte  = tx_byte(int'(sent_cnt));
            if (sent_cnt < 7) sent_cnt = sent_cnt + 3'd1;
         end else if (status == ST_DATA_W_ACK) begin
            stop       = 1'b1;
            r.done_res = 1'b1;
         end else if (status == ST_ADDR_W_NACK) begin
            stop = 1'b1;
         end else begin
            stop         = 1'b1;
            r.unexpected = 1'b1;
         end
      end else begin
         case (status)
            ST_START: begin
               r.load_valid = 1'b1;
               r.load_byte  = addr_w;
            end
            ST_ADDR_W_ACK: begin
               r.load_valid = 1'b1;
               r.load_byte  = tx_byte(0);
            end
            ST_ADDR_W_NACK: stop = 1'b1;
            ST_DATA_W_ACK:  r.ctl_start = 1'b1;
            ST_RSTART: begin
               r.load_valid = 1'b1;
               r.load_byte  = addr_w | 8'h01;
            end
            ST_ADDR_R_ACK: r.ctl_ack = (rxl > 1);
            ST_DATA_R_ACK: begin
               r.rx_valid = 1'b1;
               r.rx_byte  = data;
               r.rx_index = recv_cnt[3:0];
               nxt        = (recv_cnt < 31) ? int'(recv_cnt) + 1 : 31;
               recv_cnt   = 5'(nxt);
               r.ctl_ack  = (nxt + 1 < rxl);
            end
            ST_DATA_R_NACK: begin
               r.rx_valid = 1'b1;
               r.rx_byte  = data;
               r.rx_index = recv_cnt[3:0];
               stop       = 1'b1;
               r.done_res = 1'b1;
            end
            default: begin
               stop         = 1'b1;
               r.unexpected = 1'b1;
            end
         endcase
      end
      if (stop) begin
         r.ctl_stop = 1'b1;
         sent_cnt   = '0;
         recv_cnt   = '0;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // status driver
   always @(posedge clock) begin
      status_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (queued_events.size() > 0) begin
            ev = queued_events.pop_front();
            req_valid       <= 1'b1;
            req_bus_status  <= ev.status;
            req_bus_data_in <= ev.data;
            if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1)
               gap_left <= $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result-side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_odds > 0 && $urandom_range(1, stall_odds) == 1) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: shadow registers, prediction and result checking
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         reg_shadow = '{read_mode: 1'b0, device_address: 7'd64, tx_length: 3'd1,
                        rx_length: 5'd3, tx_bytes: 32'd0};
         sent_cnt   = '0;
         recv_cnt   = '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_READ_MODE:      reg_shadow.read_mode      = csr_data[0];
               CSR_DEVICE_ADDRESS: reg_shadow.device_address = csr_data[6:0];
               CSR_TX_LENGTH:      reg_shadow.tx_length      = csr_data[2:0];
               CSR_RX_LENGTH:      reg_shadow.rx_length      = csr_data[4:0];
               CSR_TX_BYTES:       reg_shadow.tx_bytes       = csr_data[31:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_actions.push_back(next_bus_action(req_bus_status, req_bus_data_in));
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{load_valid: rsp_load_valid, load_byte: rsp_load_byte,
                    ctl_start: rsp_ctl_start, ctl_stop: rsp_ctl_stop, ctl_ack: rsp_ctl_ack,
                    rx_valid: rsp_rx_valid, rx_byte: rsp_rx_byte, rx_index: rsp_rx_index,
                    done_res: rsp_done_res, unexpected: rsp_unexpected};
            beats_out++;
            if (pending_actions.size() == 0) begin
               $error("result beat with no status event outstanding");
               mismatches++;
            end else begin
               want = pending_actions.pop_front();
               check_field("load_valid", 8'(want.load_valid), 8'(got.load_valid));
               check_field("load_byte",  want.load_byte,      got.load_byte);
               check_field("ctl_start",  8'(want.ctl_start),  8'(got.ctl_start));
               check_field("ctl_stop",   8'(want.ctl_stop),   8'(got.ctl_stop));
               check_field("ctl_ack",    8'(want.ctl_ack),    8'(got.ctl_ack));
               check_field("rx_valid",   8'(want.rx_valid),   8'(got.rx_valid));
               check_field("rx_byte",    want.rx_byte,        got.rx_byte);
               check_field("rx_index",   8'(want.rx_index),   8'(got.rx_index));
               check_field("done_res",   8'(want.done_res),   8'(got.done_res));
               check_field("unexpected", 8'(want.unexpected), 8'(got.unexpected));
               if (want.done_res) transfers_done++;
               if (want.unexpected) unexpected_seen++;
            end
         end
      end
   end

   // watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic stage(logic [7:0] status, int data);
      seq.push_back('{status, 8'(data)});
   endtask

   task automatic flush_staged();
      while (seq.size() > 0) begin
         queued_events.push_back(seq.pop_front());
         events_staged++;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (queued_events.size() != 0 || req_valid || pending_actions.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one register per cycle, write enable dropped after the last
   task automatic program_registers(cfg_type c);
      logic [CSR_INDEX_W-1:0] order[5] = '{CSR_READ_MODE, CSR_DEVICE_ADDRESS,
                                           CSR_TX_LENGTH, CSR_RX_LENGTH, CSR_TX_BYTES};
      logic [CSR_DATA_W-1:0]  value;
      foreach (order[i]) begin
         case (order[i])
            CSR_READ_MODE:      value = CSR_DATA_W'(c.read_mode);
            CSR_DEVICE_ADDRESS: value = CSR_DATA_W'(c.device_address);
            CSR_TX_LENGTH:      value = CSR_DATA_W'(c.tx_length);
            CSR_RX_LENGTH:      value = CSR_DATA_W'(c.rx_length);
            default:            value = c.tx_bytes;
         endcase
         @(posedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= order[i];
         csr_data     <= value;
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   function automatic cfg_type pick_setting(int phase);
      cfg_type c;
      if (phase == 0) begin
         c = '0;
      end else if (phase == 1) begin
         c = '{read_mode: 1'b1, device_address: 7'h7f, tx_length: 3'd7,
               rx_length: 5'd31, tx_bytes: 32'hffff_ffff};
      end else begin
         c.read_mode      = 1'($urandom_range(0, 1));
         c.device_address = 7'($urandom_range(0, 127));
         c.tx_length      = 3'($urandom_range(0, 7));
         c.rx_length      = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 6));
         c.tx_bytes       = $urandom;
      end
      return c;
   endfunction

   function automatic status_event_type noise_event();
      status_event_type ev;
      ev.status = $urandom_range(0, 1) ? known_codes[$urandom_range(0, 7)]
                                       : 8'($urandom_range(0, 255));
      ev.data   = 8'($urandom_range(0, 255));
      return ev;
   endfunction

   // well-formed transfer for the current mode and lengths
   task automatic build_transfer();
      int txl;
      int rxl;
      int extra;
      txl = clamp_len(int'(reg_shadow.tx_length), TX_DEPTH);
      rxl = clamp_len(int'(reg_shadow.rx_length), RX_DEPTH);
      stage(ST_START, $urandom_range(0, 255));
      stage(ST_ADDR_W_ACK, $urandom_range(0, 255));
      if (!reg_shadow.read_mode) begin
         repeat (txl) stage(ST_DATA_W_ACK, $urandom_range(0, 255));
      end else begin
         extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
         stage(ST_DATA_W_ACK, $urandom_range(0, 255));
         stage(ST_RSTART, $urandom_range(0, 255));
         stage(ST_ADDR_R_ACK, $urandom_range(0, 255));
         repeat (rxl - 1 + extra) stage(ST_DATA_R_ACK, $urandom_range(0, 255));
         stage(ST_DATA_R_NACK, $urandom_range(0, 255));
      end
   endtask

   task automatic add_random_sequence();
      int kind;
      int keep;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         build_transfer();
      end else if (kind == 7) begin
         // transfer cut short, then a NACK or a stray status
         build_transfer();
         keep = $urandom_range(1, seq.size() - 1);
         while (seq.size() > keep) void'(seq.pop_back());
         if ($urandom_range(0, 1))
            stage(ST_ADDR_W_NACK, $urandom_range(0, 255));
         else
            seq.push_back(noise_event());
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 3)) seq.push_back(noise_event());
      end else if (!reg_shadow.read_mode) begin
         // saturate the send count and run past the stored bytes
         stage(ST_START, $urandom_range(0, 255));
         repeat (10) stage(ST_ADDR_W_ACK, $urandom_range(0, 255));
         stage(ST_DATA_W_ACK, $urandom_range(0, 255));
      end else begin
         // wrap the index and saturate the receive count
         repeat (34) stage(ST_DATA_R_ACK, $urandom_range(0, 255));
         stage(ST_DATA_R_NACK, $urandom_range(0, 255));
      end
      flush_staged();
   endtask

   initial begin
      int phase;
      int directed_count;
      int target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // write mode at reset settings: clean transfer, address NACK, odd codes
      stage(ST_START, 8'h00);
      stage(ST_ADDR_W_ACK, 8'hff);
      stage(ST_DATA_W_ACK, 8'h00);
      stage(ST_START, 8'h12);
      stage(ST_ADDR_W_NACK, 8'h34);
      stage(8'h00, 8'hff);
      stage(8'hff, 8'h00);
      stage(ST_ADDR_W_ACK, 8'h56);
      stage(ST_ADDR_W_ACK, 8'h78);
      flush_staged();
      wait_drained();

      // read mode: command, repeated start, four bytes with rx length two, address NACK, odd code
      program_registers('{read_mode: 1'b1, device_address: 7'h7f, tx_length: 3'd4,
                          rx_length: 5'd2, tx_bytes: 32'ha5c3_5aff});
      stage(ST_START, 8'h00);
      stage(ST_ADDR_W_ACK, 8'h00);
      stage(ST_DATA_W_ACK, 8'h00);
      stage(ST_RSTART, 8'h00);
      stage(ST_ADDR_R_ACK, 8'h00);
      stage(ST_DATA_R_ACK, 8'h00);
      stage(ST_DATA_R_ACK, 8'hff);
      stage(ST_DATA_R_ACK, 8'haa);
      stage(ST_DATA_R_NACK, 8'h5a);
      stage(ST_START, 8'h00);
      stage(ST_ADDR_W_NACK, 8'h00);
      stage(8'h41, 8'h81);
      flush_staged();
      wait_drained();
      directed_count = events_staged;

      phase = 0;
      while (events_staged - directed_count < RANDOM_ITEMS) begin
         program_registers(pick_setting(phase));
         if (events_staged - directed_count > RANDOM_ITEMS - 60) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: gap_odds = 0;
               1: gap_odds = 3;
               default: gap_odds = 10;
            endcase
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 3;
               default: stall_odds = 10;
            endcase
         end
         target = events_staged + $urandom_range(30, 60);
         while (events_staged < target) add_random_sequence();
         wait_drained();
         phase++;
      end

      repeat (10) @(negedge clock);
      if (pending_actions.size() != 0) begin
         $error("%0d predicted bus actions never arrived", pending_actions.size());
         mismatches++;
      end
      $display("covered %0d status beats and %0d result beats under %0d register settings",
               beats_in, beats_out, settings_used);
      $display("%0d transfers ended normally, %0d statuses flagged unexpected, %0d mismatches",
               transfers_done, unexpected_seen, mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
hdl/i2cms_pkg.sv
hdl/i2cms_csr.sv
hdl/i2cms_step.sv
hdl/i2c_master_status_sequencer.sv
dv/i2c_master_status_sequencer_test.sv
